// ----- src/rsos_pkg.sv -----
// shared types and constants for the range-sum block over arrival and sorted order
package rsos_pkg;

	localparam int POS_W      = 10;
	localparam int VAL_IN_W   = 30;
	localparam int VAL_WIDE_W = 48;
	localparam int SUM_W      = 40;

	typedef enum logic [1:0] {
		OP_CLEAR       = 2'd0,
		OP_LOAD        = 2'd1,
		OP_SUM_ARRIVAL = 2'd2,
		OP_SUM_SORTED  = 2'd3
	} op_t;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_RANGE = 1'b1;

	typedef struct packed {
		op_t                 op;
		logic [VAL_IN_W-1:0] value;
		logic [POS_W-1:0]    first_pos;
		logic [POS_W-1:0]    last_pos;
	} item_t;

	typedef struct packed {
		logic [SUM_W-1:0] range_sum;
		logic             status;
	} result_t;

	// broadcast controls from the top level to every cell
	typedef struct packed {
		logic load;
		logic query;
		logic lo_ok;
	} cell_ctrl_t;

endpackage

// ----- src/range_sum_original_and_sorted.sv -----
// top level: range sums over values in arrival order and in sorted order
// loads and clears leave the state machine idle and may follow back to back
// a query's result is registered in order through cell select and memory read,
// or-reduction over the cell chain, then the 40-bit subtract; no new beat is taken until it is done
// the last stage holds while an earlier result waits unread, which delays the next beat
// reset clears the loaded count, the state machine and the result valid; stores hold garbage
module range_sum_original_and_sorted #(
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 30
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rsos_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output rsos_pkg::result_t result
);

	localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW   = $clog2(MAX_ITEMS + 1);
	localparam int CMPW = (CW > rsos_pkg::POS_W) ? CW : rsos_pkg::POS_W;
	localparam int SW   = rsos_pkg::SUM_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REDUCE = 3'b010,
		ST_DIFF   = 3'b100
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [SW-1:0]         arr_last_q;
	logic [SW-1:0]         arr_mem [MAX_ITEMS];
	logic [SW-1:0]         arr_hi_q;
	logic [SW-1:0]         arr_lo_q;
	logic                  sorted_q;
	logic                  err_q;
	logic                  lo_ok_q;
	logic [SW-1:0]         sel_hi_q;
	logic [SW-1:0]         sel_lo_q;
	rsos_pkg::result_t     result_q;
	logic                  result_valid_q;

	logic                  fire;
	logic                  load_en;
	logic                  clear_en;
	logic                  query_en;
	logic                  bad_range;
	logic [VALUE_BITS-1:0] v;
	logic [rsos_pkg::VAL_WIDE_W-1:0] v_wide;
	logic [AW-1:0]         hi_idx;
	logic [AW-1:0]         lo_idx;
	rsos_pkg::cell_ctrl_t  ctrl;
	logic [SW-1:0]         or_hi;
	logic [SW-1:0]         or_lo;

	logic [VALUE_BITS-1:0] chain_val [MAX_ITEMS];
	logic [SW-1:0]         chain_pre [MAX_ITEMS];
	logic                  chain_gt  [MAX_ITEMS];
	logic [SW-1:0]         hit_hi    [MAX_ITEMS];
	logic [SW-1:0]         hit_lo    [MAX_ITEMS];

	// input beat decode
	assign item_ready = (state_q == ST_IDLE);
	assign fire       = item_valid && item_ready;
	assign v_wide     = rsos_pkg::VAL_WIDE_W'(item.value);
	assign v          = v_wide[VALUE_BITS-1:0];
	assign hi_idx     = AW'(item.last_pos);
	assign lo_idx     = AW'(item.first_pos - rsos_pkg::POS_W'(1));
	assign bad_range  = (item.last_pos < item.first_pos) ||
	                    (CMPW'(item.last_pos) >= CMPW'(count_q));

	always_comb begin
		load_en  = 1'b0;
		clear_en = 1'b0;
		query_en = 1'b0;
		unique case (item.op)
			rsos_pkg::OP_CLEAR:       clear_en = fire;
			rsos_pkg::OP_LOAD:        load_en  = fire && (count_q < CW'(MAX_ITEMS));
			rsos_pkg::OP_SUM_ARRIVAL: query_en = fire;
			rsos_pkg::OP_SUM_SORTED:  query_en = fire;
			default:                  query_en = 1'b0;
		endcase
	end

	assign ctrl.load  = load_en;
	assign ctrl.query = query_en && (item.op == rsos_pkg::OP_SUM_SORTED);
	assign ctrl.lo_ok = (item.first_pos != '0);

	// sorted store as a chain of cells
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic [VALUE_BITS-1:0] lv;
		logic [SW-1:0]         lp;
		logic                  lg;
		if (i == 0) begin : g_head
			assign lv = '0;
			assign lp = '0;
			assign lg = 1'b0;
		end else begin : g_link
			assign lv = chain_val[i-1];
			assign lp = chain_pre[i-1];
			assign lg = chain_gt[i-1];
		end
		rsos_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS),
			.AW         (AW),
			.CW         (CW)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.v        (v),
			.count    (count_q),
			.hi_idx   (hi_idx),
			.lo_idx   (lo_idx),
			.left_val (lv),
			.left_pre (lp),
			.left_gt  (lg),
			.val      (chain_val[i]),
			.pre      (chain_pre[i]),
			.gt       (chain_gt[i]),
			.hit_hi   (hit_hi[i]),
			.hit_lo   (hit_lo[i])
		);
	end

	// arrival-order prefix memory: append on load, two reads on query
	always_ff @(posedge clk) begin
		if (load_en) begin
			arr_mem[count_q[AW-1:0]] <= ((count_q == '0) ? '0 : arr_last_q) + SW'(v);
		end
		if (query_en) begin
			arr_hi_q <= arr_mem[hi_idx];
			arr_lo_q <= arr_mem[lo_idx];
		end
	end

	// running last arrival prefix
	always_ff @(posedge clk) begin
		if (load_en) begin
			arr_last_q <= ((count_q == '0) ? '0 : arr_last_q) + SW'(v);
		end
	end

	// query attributes held through the pipeline
	always_ff @(posedge clk) begin
		if (query_en) begin
			sorted_q <= (item.op == rsos_pkg::OP_SUM_SORTED);
			err_q    <= bad_range;
			lo_ok_q  <= (item.first_pos != '0);
		end
	end

	// or-reduction over the one-hot cell hits
	always_comb begin
		or_hi = '0;
		or_lo = '0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			or_hi = or_hi | hit_hi[i];
			or_lo = or_lo | hit_lo[i];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REDUCE) begin
			sel_hi_q <= sorted_q ? or_hi : arr_hi_q;
			sel_lo_q <= sorted_q ? or_lo : (lo_ok_q ? arr_lo_q : '0);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIFF) && (!result_valid_q || result_ready)) begin
			if (err_q) begin
				result_q.range_sum <= '0;
				result_q.status    <= rsos_pkg::STATUS_BAD_RANGE;
			end else begin
				result_q.range_sum <= sel_hi_q - sel_lo_q;
				result_q.status    <= rsos_pkg::STATUS_OK;
			end
		end
	end

	// control: state, loaded count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DIFF) && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (clear_en) begin
				count_q <= '0;
			end else if (load_en) begin
				count_q <= count_q + CW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (query_en) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					if (!result_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- src/rsos_cell.sv -----
// one slot of the sorted store: value and prefix sum, shifts right on insert
module rsos_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 30,
	parameter int AW         = 10,
	parameter int CW         = 11
) (
	input  logic                         clk,
	input  rsos_pkg::cell_ctrl_t         ctrl,
	input  logic [VALUE_BITS-1:0]        v,
	input  logic [CW-1:0]                count,
	input  logic [AW-1:0]                hi_idx,
	input  logic [AW-1:0]                lo_idx,
	input  logic [VALUE_BITS-1:0]        left_val,
	input  logic [rsos_pkg::SUM_W-1:0]   left_pre,
	input  logic                         left_gt,
	output logic [VALUE_BITS-1:0]        val,
	output logic [rsos_pkg::SUM_W-1:0]   pre,
	output logic                         gt,
	output logic [rsos_pkg::SUM_W-1:0]   hit_hi,
	output logic [rsos_pkg::SUM_W-1:0]   hit_lo
);

	localparam logic [CW-1:0] MY_POS = CW'(IDX);
	localparam logic [AW-1:0] MY_ADR = AW'(IDX);

	logic [VALUE_BITS-1:0]      val_q;
	logic [rsos_pkg::SUM_W-1:0] pre_q;
	logic [rsos_pkg::SUM_W-1:0] hit_hi_q;
	logic [rsos_pkg::SUM_W-1:0] hit_lo_q;
	logic                       self_ins;

	// occupied slot holding a value above the new one
	assign gt = (MY_POS < count) && (val_q > v);

	// new value lands here: first slot above it, or the free slot at the end
	assign self_ins = (MY_POS <= count) && (gt || (MY_POS == count));

	// insert: shift from the left neighbor or take the new value
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			if (left_gt) begin
				val_q <= left_val;
				pre_q <= left_pre + rsos_pkg::SUM_W'(v);
			end else if (self_ins) begin
				val_q <= v;
				pre_q <= left_pre + rsos_pkg::SUM_W'(v);
			end
		end
	end

	// query: offer the prefix when this slot is addressed, zero otherwise
	always_ff @(posedge clk) begin
		if (ctrl.query) begin
			hit_hi_q <= (MY_ADR == hi_idx) ? pre_q : '0;
			hit_lo_q <= (ctrl.lo_ok && (MY_ADR == lo_idx)) ? pre_q : '0;
		end
	end

	assign val    = val_q;
	assign pre    = pre_q;
	assign hit_hi = hit_hi_q;
	assign hit_lo = hit_lo_q;

endmodule

// ----- tb/sv/range_sum_original_and_sorted_tb.sv -----
`timescale 1ns / 100ps
// testbench for the range-sum block: checks arrival-order and sorted-order sums
module range_sum_original_and_sorted_tb;

	localparam int CAPACITY     = 1024;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 100;
	localparam int FILL_LOADS   = 60;
	localparam int FILL_QUERIES = 20;
	localparam int SCRIPT_ROWS  = 20;

	localparam logic [rsos_pkg::VAL_IN_W-1:0] VAL_MAX = '1;
	localparam logic [rsos_pkg::POS_W-1:0]    POS_MAX = '1;

	localparam rsos_pkg::result_t NONE =
		'{range_sum: '0, status: rsos_pkg::STATUS_OK};
	localparam rsos_pkg::result_t BAD =
		'{range_sum: '0, status: rsos_pkg::STATUS_BAD_RANGE};
	localparam rsos_pkg::result_t LONE_MAX =
		'{range_sum: rsos_pkg::SUM_W'(VAL_MAX), status: rsos_pkg::STATUS_OK};

	typedef struct packed {
		rsos_pkg::item_t   beat;
		logic              typed;
		rsos_pkg::result_t want;
	} script_row_t;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	rsos_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	rsos_pkg::result_t result;

	// shadow copy of the block's stores
	int                            held_count;
	logic [rsos_pkg::SUM_W-1:0]    arrival_sums [CAPACITY];
	logic [rsos_pkg::VAL_IN_W-1:0] ordered_vals [CAPACITY];
	logic [rsos_pkg::SUM_W-1:0]    ordered_sums [CAPACITY];

	rsos_pkg::result_t expected_results [$];
	int                error_count;
	int                tx_idle_pct;
	int                rx_idle_pct;

	// directed beats; the sorted store after the loads holds 0, 3, 5, 5, max
	script_row_t script [SCRIPT_ROWS] = '{
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, 10'd0, 10'd0}, 1'b1, BAD},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, 10'd0}, 1'b1, BAD},
		'{'{rsos_pkg::OP_LOAD, VAL_MAX, 10'd0, 10'd0}, 1'b0, NONE},
		'{'{rsos_pkg::OP_LOAD, 30'd0, POS_MAX, POS_MAX}, 1'b0, NONE},
		'{'{rsos_pkg::OP_LOAD, 30'd5, 10'd0, 10'd0}, 1'b0, NONE},
		'{'{rsos_pkg::OP_LOAD, 30'd5, 10'd0, 10'd0}, 1'b0, NONE},
		'{'{rsos_pkg::OP_LOAD, 30'd3, 10'd0, 10'd0}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, 10'd0, 10'd0}, 1'b1, LONE_MAX},
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, 10'd0, 10'd4}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, 10'd4}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd1, 10'd2}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, 10'd2, 10'd4}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, 10'd3, 10'd2}, 1'b1, BAD},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, 10'd5}, 1'b1, BAD},
		'{'{rsos_pkg::OP_SUM_ARRIVAL, 30'd0, POS_MAX, POS_MAX}, 1'b1, BAD},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, POS_MAX}, 1'b1, BAD},
		'{'{rsos_pkg::OP_CLEAR, VAL_MAX, POS_MAX, POS_MAX}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, 10'd0}, 1'b1, BAD},
		'{'{rsos_pkg::OP_LOAD, VAL_MAX, POS_MAX, 10'd0}, 1'b0, NONE},
		'{'{rsos_pkg::OP_SUM_SORTED, 30'd0, 10'd0, 10'd0}, 1'b1, LONE_MAX}
	};

	range_sum_original_and_sorted dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// apply one accepted beat to the shadow stores and work out the sum a query yields
	task automatic predict_beat(input rsos_pkg::item_t it, output logic has_sum,
		output rsos_pkg::result_t sum);
		int                         spot;
		logic [rsos_pkg::SUM_W-1:0] upper;
		logic [rsos_pkg::SUM_W-1:0] below;
		logic [rsos_pkg::SUM_W-1:0] add;
		has_sum = 1'b0;
		sum     = NONE;
		add     = rsos_pkg::SUM_W'(it.value);
		case (it.op)
		rsos_pkg::OP_CLEAR: begin
			held_count = 0;
		end
		rsos_pkg::OP_LOAD: begin
			// a full store drops the value
			if (held_count < CAPACITY) begin
				arrival_sums[held_count] =
					(held_count == 0 ? '0 : arrival_sums[held_count-1]) + add;
				// equal values go after the ones already held
				spot = 0;
				while (spot < held_count && ordered_vals[spot] <= it.value) spot++;
				for (int i = held_count; i > spot; i--) begin
					ordered_vals[i] = ordered_vals[i-1];
					ordered_sums[i] = ordered_sums[i-1] + add;
				end
				ordered_vals[spot] = it.value;
				ordered_sums[spot] = (spot == 0 ? '0 : ordered_sums[spot-1]) + add;
				held_count++;
			end
		end
		default: begin
			has_sum = 1'b1;
			if (it.last_pos < it.first_pos || it.last_pos >= held_count) begin
				sum = BAD;
			end else begin
				if (it.op == rsos_pkg::OP_SUM_ARRIVAL) begin
					upper = arrival_sums[it.last_pos];
					below = (it.first_pos == 0) ? '0 : arrival_sums[it.first_pos - 1];
				end else begin
					upper = ordered_sums[it.last_pos];
					below = (it.first_pos == 0) ? '0 : ordered_sums[it.first_pos - 1];
				end
				sum = '{range_sum: upper - below, status: rsos_pkg::STATUS_OK};
			end
		end
		endcase
	endtask

	// random command: mostly loads and in-range queries, a few clears and broken ranges
	function automatic rsos_pkg::item_t draw_command();
		rsos_pkg::item_t it;
		int              pick;
		int              flavor;
		pick         = $urandom_range(99);
		flavor       = $urandom_range(2);
		it.op        = rsos_pkg::OP_CLEAR;
		it.value     = rsos_pkg::VAL_IN_W'($urandom());
		it.first_pos = rsos_pkg::POS_W'($urandom());
		it.last_pos  = rsos_pkg::POS_W'($urandom());
		if (pick >= 3 && pick < 50) begin
			it.op = rsos_pkg::OP_LOAD;
			// small values and copies of held ones give plenty of ties
			if (flavor == 0) begin
				it.value = rsos_pkg::VAL_IN_W'($urandom_range(15));
			end else if (flavor == 1 && held_count > 0) begin
				it.value = ordered_vals[$urandom_range(held_count - 1)];
			end
		end else if (pick >= 50) begin
			it.op = $urandom_range(1) ? rsos_pkg::OP_SUM_SORTED : rsos_pkg::OP_SUM_ARRIVAL;
			if (pick < 88 && held_count > 0) begin
				it.last_pos  = rsos_pkg::POS_W'($urandom_range(held_count - 1));
				it.first_pos = rsos_pkg::POS_W'($urandom_range(it.last_pos));
			end
		end
		return it;
	endfunction

	// present one beat, wait for it to be taken, then queue what it should yield
	task automatic send_beat(input rsos_pkg::item_t it, input logic typed,
		input rsos_pkg::result_t want);
		logic              has_sum;
		rsos_pkg::result_t sum;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		predict_beat(it, has_sum, sum);
		if (has_sum) expected_results.insert(expected_results.size(), typed ? want : sum);
	endtask

	// hold off the sender until every queued sum has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// stimulus
	initial begin
		rsos_pkg::item_t it;
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		error_count = 0;
		held_count  = 0;
		tx_idle_pct = 24;
		rx_idle_pct = 67;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) send_beat(script[r].beat, script[r].typed, script[r].want);
		wait_drained();

		// sender light and receiver heavy, then swapped, then neither idles
		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 67 : 0;
			rx_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 24 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_beat(draw_command(), 1'b0, NONE);
				if ($urandom_range(49) == 0) wait_drained();
			end
			wait_drained();
		end

		// a long run of loads after a clear, then queries across the whole span
		it    = '0;
		it.op = rsos_pkg::OP_CLEAR;
		send_beat(it, 1'b0, NONE);
		it.op = rsos_pkg::OP_LOAD;
		for (int n = 0; n < FILL_LOADS; n++) begin
			it.value = $urandom_range(1) ? rsos_pkg::VAL_IN_W'($urandom()) :
				rsos_pkg::VAL_IN_W'($urandom_range(63));
			send_beat(it, 1'b0, NONE);
		end
		for (int n = 0; n < FILL_QUERIES; n++) begin
			it.op        = (n % 2) ? rsos_pkg::OP_SUM_SORTED : rsos_pkg::OP_SUM_ARRIVAL;
			it.last_pos  = (n < 2) ? rsos_pkg::POS_W'(FILL_LOADS - 1) :
				rsos_pkg::POS_W'($urandom_range(FILL_LOADS));
			it.first_pos = (n < 2) ? '0 : rsos_pkg::POS_W'($urandom_range(it.last_pos));
			send_beat(it, 1'b0, NONE);
		end
		wait_drained();

		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// result side: random back-pressure and field checks against the oldest queued sum
	initial begin
		rsos_pkg::result_t want;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no query waiting: range_sum %0d status %0d",
						result.range_sum, result.status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.range_sum !== want.range_sum) begin
						$error("range_sum: expected %0d, got %0d", want.range_sum, result.range_sum);
						error_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						error_count++;
					end
				end
			end
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
			else quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
src/rsos_pkg.sv
src/rsos_cell.sv
src/range_sum_original_and_sorted.sv
tb/sv/range_sum_original_and_sorted_tb.sv
